// ----- hdl/cts_pkg.sv -----
// cts_pkg: shared constants, codes, types and helper functions for the
// client table scheduler; no dependencies
package cts_pkg;

    // table geometry
    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    // field widths
    localparam int VAL_W    = 16;
    localparam int CMD_W    = 2;
    localparam int SLOT_W   = 4;
    localparam int POLICY_W = 2;
    localparam int STATUS_W = 2;
    localparam int CHOSEN_W = 4;
    localparam int TOTAL_W  = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int CMP_W    = (SLOT_W > CNT_W) ? SLOT_W + 1 : CNT_W + 1;

    // commands
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SERVE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

    // selection policies
    localparam logic [POLICY_W-1:0] POLICY_FIRST    = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_SMALLEST = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_RR       = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHARGE = 1'd1;

    // register reset values
    localparam logic [POLICY_W-1:0] POLICY_RESET = POLICY_SMALLEST;
    localparam logic [VAL_W-1:0]    CHARGE_RESET = 16'd73;

    // chain operations
    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_ROTATE = 3'd1;
    localparam logic [2:0] OP_LOAD   = 3'd2;
    localparam logic [2:0] OP_SHIFT  = 3'd3;
    localparam logic [2:0] OP_CHARGE = 3'd4;

    // command from the controller to the row of cells
    typedef struct packed {
        logic [2:0]       op;
        logic [IDX_W-1:0] index;
        logic [VAL_W-1:0] data;
    } cts_chain_cmd_t;

    // per-cell controls
    typedef struct packed {
        logic take_nbr;
        logic load;
        logic charge;
    } cts_cell_ctl_t;

    // subtract with a floor at zero
    function automatic logic [VAL_W-1:0] sat_sub(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    // index of the lowest set bit, zero when none is set
    function automatic logic [IDX_W-1:0] lowest_set(input logic [MAX_ENTRIES-1:0] m);
        logic [IDX_W-1:0] idx;
        idx = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (m[i]) begin
                idx = IDX_W'(i);
            end
        end
        return idx;
    endfunction

    // bits at positions at or above s
    function automatic logic [MAX_ENTRIES-1:0] ge_mask(input logic [IDX_W-1:0] s);
        logic [MAX_ENTRIES-1:0] r;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            r[i] = (IDX_W'(i) >= s);
        end
        return r;
    endfunction

endpackage

// ----- hdl/client_table_scheduler.sv -----
// client_table_scheduler: top level with command sequencer, scan logic,
// configuration registers and result register; depends on cts_pkg, cts_chain

// The table lives in a ring of 16 cells. Add, remove and ignored commands
// go to S_FINISH, which loads the result register once the output is free.
// Serve on a non-empty table rotates the ring once through all 16 cells,
// inspecting the head one entry per cycle, then S_FINISH picks the entry
// and charges it in place. A new item is taken as soon as the previous one
// has been written to the result register, even if that result is not yet
// transferred. Configuration writes take effect on the next cycle.
module client_table_scheduler (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration
    input  logic                              cfg_we,
    input  logic [cts_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cts_pkg::CFG_DATA_W-1:0]    cfg_data,
    // command channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [cts_pkg::CMD_W-1:0]         s_cmd,
    input  logic [cts_pkg::VAL_W-1:0]         s_size,
    input  logic [cts_pkg::SLOT_W-1:0]        s_slot,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_picked,
    output logic [cts_pkg::CHOSEN_W-1:0]      m_chosen_index,
    output logic                              m_fallback,
    output logic [cts_pkg::STATUS_W-1:0]      m_status,
    output logic [cts_pkg::TOTAL_W-1:0]       m_entry_total
);
    import cts_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    localparam logic [IDX_W-1:0] SCAN_LAST = IDX_W'(MAX_ENTRIES - 1);

    logic [1:0]             state_reg, state_next;
    logic [POLICY_W-1:0]    policy_reg;
    logic [VAL_W-1:0]       charge_reg;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [IDX_W-1:0]       rr_reg, rr_next;
    logic [CMD_W-1:0]       cmd_reg;
    logic [VAL_W-1:0]       size_reg;
    logic [SLOT_W-1:0]      slot_reg;
    logic [IDX_W-1:0]       scan_cnt_reg, scan_cnt_next;
    logic [CNT_W-1:0]       start_reg, start_next;
    logic [MAX_ENTRIES-1:0] mask_reg, mask_next;
    logic [IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [VAL_W-1:0]       best_val_reg, best_val_next;
    logic                   best_found_reg, best_found_next;

    logic                   m_valid_reg;
    logic                   picked_reg;
    logic [CHOSEN_W-1:0]    chosen_reg;
    logic                   fallback_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [TOTAL_W-1:0]     total_reg;

    logic                   s_fire;
    logic                   out_free;
    logic                   out_load;
    logic                   res_picked;
    logic [IDX_W-1:0]       res_chosen;
    logic                   res_fallback;
    logic [STATUS_W-1:0]    res_status;

    logic [VAL_W-1:0]       head_val;
    logic                   head_pend;
    cts_chain_cmd_t         chain_cmd;

    logic                   any_pend;
    logic [IDX_W-1:0]       first_idx;
    logic [MAX_ENTRIES-1:0] rr_mask;
    logic [IDX_W-1:0]       rr_idx;
    logic [IDX_W-1:0]       pick_idx;

    assign s_fire   = s_valid && s_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    // row of table cells
    cts_chain u_chain (
        .aclk          (aclk),
        .cmd           (chain_cmd),
        .charge_amount (charge_reg),
        .head_val      (head_val)
    );

    // entry at the head is pending when in range and still owed bytes
    assign head_pend = (CMP_W'(scan_cnt_reg) < CMP_W'(count_reg)) && (head_val != '0);

    // selection from the scan results
    always_comb begin
        any_pend  = |mask_reg;
        first_idx = lowest_set(mask_reg);
        rr_mask   = mask_reg & ge_mask(start_reg[IDX_W-1:0]);
        rr_idx    = (|rr_mask) ? lowest_set(rr_mask) : first_idx;
        if (!any_pend) begin
            pick_idx = '0;
        end else if (policy_reg == POLICY_SMALLEST) begin
            pick_idx = best_idx_reg;
        end else if (policy_reg == POLICY_RR) begin
            pick_idx = rr_idx;
        end else begin
            pick_idx = first_idx;
        end
    end

    // command sequencer
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        rr_next         = rr_reg;
        scan_cnt_next   = scan_cnt_reg;
        start_next      = start_reg;
        mask_next       = mask_reg;
        best_idx_next   = best_idx_reg;
        best_val_next   = best_val_reg;
        best_found_next = best_found_reg;
        chain_cmd.op    = OP_NONE;
        chain_cmd.index = '0;
        chain_cmd.data  = size_reg;
        out_load        = 1'b0;
        res_picked      = 1'b0;
        res_chosen      = '0;
        res_fallback    = 1'b0;
        res_status      = STATUS_OK;

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    scan_cnt_next   = '0;
                    best_found_next = 1'b0;
                    start_next      = CNT_W'(rr_reg) + CNT_W'(1);
                    if ((s_cmd == CMD_SERVE) && (count_reg != '0)) begin
                        state_next = S_SCAN;
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_SCAN: begin
                // rotate the ring; the head holds the entry at scan_cnt_reg
                chain_cmd.op = OP_ROTATE;
                mask_next[scan_cnt_reg] = head_pend;
                if (head_pend && (!best_found_reg || (head_val < best_val_reg))) begin
                    best_found_next = 1'b1;
                    best_idx_next   = scan_cnt_reg;
                    best_val_next   = head_val;
                end
                // reduce the round-robin start modulo the entry count
                if (start_reg >= count_reg) begin
                    start_next = start_reg - count_reg;
                end
                if (scan_cnt_reg == SCAN_LAST) begin
                    state_next = S_FINISH;
                end else begin
                    scan_cnt_next = scan_cnt_reg + IDX_W'(1);
                end
            end

            S_FINISH: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    unique case (cmd_reg)
                        CMD_ADD: begin
                            if (CMP_W'(count_reg) < CMP_W'(MAX_ENTRIES)) begin
                                chain_cmd.op    = OP_LOAD;
                                chain_cmd.index = count_reg[IDX_W-1:0];
                                count_next      = count_reg + CNT_W'(1);
                            end else begin
                                res_status = STATUS_FULL;
                            end
                        end
                        CMD_SERVE: begin
                            if (count_reg == '0) begin
                                res_status = STATUS_EMPTY;
                            end else begin
                                chain_cmd.op    = OP_CHARGE;
                                chain_cmd.index = pick_idx;
                                res_picked      = 1'b1;
                                res_chosen      = pick_idx;
                                res_fallback    = !any_pend;
                                if (policy_reg == POLICY_RR) begin
                                    rr_next = pick_idx;
                                end
                            end
                        end
                        CMD_REMOVE: begin
                            if (CMP_W'(slot_reg) < CMP_W'(count_reg)) begin
                                chain_cmd.op    = OP_SHIFT;
                                chain_cmd.index = IDX_W'(slot_reg);
                                count_next      = count_reg - CNT_W'(1);
                            end else begin
                                res_status = STATUS_EMPTY;
                            end
                        end
                        CMD_NOP: begin
                            res_status = STATUS_OK;
                        end
                    endcase
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            rr_reg      <= '0;
            policy_reg  <= POLICY_RESET;
            charge_reg  <= CHARGE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            rr_reg    <= rr_next;
            // configuration writes
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_POLICY: policy_reg <= cfg_data[POLICY_W-1:0];
                    REG_CHARGE: charge_reg <= cfg_data[VAL_W-1:0];
                endcase
            end
            // result valid
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // item and scan working registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg  <= s_cmd;
            size_reg <= s_size;
            slot_reg <= s_slot;
        end
        scan_cnt_reg   <= scan_cnt_next;
        start_reg      <= start_next;
        mask_reg       <= mask_next;
        best_idx_reg   <= best_idx_next;
        best_val_reg   <= best_val_next;
        best_found_reg <= best_found_next;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (out_load) begin
            picked_reg   <= res_picked;
            chosen_reg   <= CHOSEN_W'(res_chosen);
            fallback_reg <= res_fallback;
            status_reg   <= res_status;
            total_reg    <= TOTAL_W'(count_next);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_picked       = picked_reg;
    assign m_chosen_index = chosen_reg;
    assign m_fallback     = fallback_reg;
    assign m_status       = status_reg;
    assign m_entry_total  = total_reg;

endmodule

// ----- hdl/cts_cell.sv -----
// cts_cell: one table entry holding the bytes still owed, with load,
// neighbor transfer and saturating charge; depends on cts_pkg
module cts_cell (
    input  logic                        aclk,
    input  cts_pkg::cts_cell_ctl_t      ctl,
    input  logic [cts_pkg::VAL_W-1:0]   nbr_val,
    input  logic [cts_pkg::VAL_W-1:0]   load_val,
    input  logic [cts_pkg::VAL_W-1:0]   charge_amount,
    output logic [cts_pkg::VAL_W-1:0]   val
);
    import cts_pkg::*;

    logic [VAL_W-1:0] val_reg;
    logic [VAL_W-1:0] val_next;

    // neighbor transfer wins, then load, then charge
    always_comb begin
        priority if (ctl.take_nbr) begin
            val_next = nbr_val;
        end else if (ctl.load) begin
            val_next = load_val;
        end else if (ctl.charge) begin
            val_next = sat_sub(val_reg, charge_amount);
        end else begin
            val_next = val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

// ----- hdl/cts_chain.sv -----
// cts_chain: ring of table cells, each passing its entry to the cell below;
// decodes chain commands into per-cell controls; depends on cts_pkg, cts_cell
module cts_chain (
    input  logic                        aclk,
    input  cts_pkg::cts_chain_cmd_t     cmd,
    input  logic [cts_pkg::VAL_W-1:0]   charge_amount,
    output logic [cts_pkg::VAL_W-1:0]   head_val
);
    import cts_pkg::*;

    logic [VAL_W-1:0] cell_val [MAX_ENTRIES];

    for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
        cts_cell_ctl_t ctl;

        // rotate moves every entry down, shift closes the gap at index
        always_comb begin
            ctl.take_nbr = (cmd.op == OP_ROTATE) ||
                           ((cmd.op == OP_SHIFT) && (IDX_W'(i) >= cmd.index));
            ctl.load     = (cmd.op == OP_LOAD)   && (IDX_W'(i) == cmd.index);
            ctl.charge   = (cmd.op == OP_CHARGE) && (IDX_W'(i) == cmd.index);
        end

        cts_cell u_cell (
            .aclk          (aclk),
            .ctl           (ctl),
            .nbr_val       (cell_val[(i + 1) % MAX_ENTRIES]),
            .load_val      (cmd.data),
            .charge_amount (charge_amount),
            .val           (cell_val[i])
        );
    end

    assign head_val = cell_val[0];

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// testbench: self-checking bench for client_table_scheduler, a directed table followed by
// random add/serve/remove traffic; depends on cts_pkg and the scheduler rtl
module testbench;
    import cts_pkg::*;

    // policy code 3 is not named in the package; it acts as first pending
    localparam logic [POLICY_W-1:0] POLICY_ALIAS_FIRST = 2'd3;
    localparam int STALL_LIMIT  = 1000;
    localparam int PHASE_COUNT  = 8;
    localparam int PHASE_ITEMS  = 94;

    typedef struct packed {
        logic                picked;
        logic [CHOSEN_W-1:0] chosen;
        logic                fallback;
        logic [STATUS_W-1:0] status;
        logic [TOTAL_W-1:0]  total;
    } sched_result_t;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CMD_W-1:0]     cmd;
        logic [VAL_W-1:0]     value;
        logic [SLOT_W-1:0]    slot;
        logic [CFG_IDX_W-1:0] reg_sel;
        bit                   fixed;
        sched_result_t        want;
    } plan_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_POLICY;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_cmd = CMD_NOP;
    logic [VAL_W-1:0]      s_size = '0;
    logic [SLOT_W-1:0]     s_slot = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_picked;
    logic [CHOSEN_W-1:0]   m_chosen_index;
    logic                  m_fallback;
    logic [STATUS_W-1:0]   m_status;
    logic [TOTAL_W-1:0]    m_entry_total;

    // predicted scheduler state
    logic [VAL_W-1:0]      owed_bytes [MAX_ENTRIES];
    logic [TOTAL_W-1:0]    n_entries = '0;
    logic [IDX_W-1:0]      rr_last = '0;
    logic [POLICY_W-1:0]   policy_reg = POLICY_RESET;
    logic [VAL_W-1:0]      charge_reg = CHARGE_RESET;

    sched_result_t         pending_results [$];
    plan_row_t             plan [$];
    logic [POLICY_W-1:0]   policy_seq [PHASE_COUNT] = '{POLICY_FIRST, POLICY_SMALLEST,
        POLICY_RR, POLICY_ALIAS_FIRST, POLICY_RR, POLICY_SMALLEST, POLICY_FIRST, POLICY_RR};
    bit                    steady = 1'b0;
    int                    err_count = 0;
    int                    stall_cycles = 0;

    client_table_scheduler dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_size         (s_size),
        .s_slot         (s_slot),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_picked       (m_picked),
        .m_chosen_index (m_chosen_index),
        .m_fallback     (m_fallback),
        .m_status       (m_status),
        .m_entry_total  (m_entry_total)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic sched_result_t outcome(input logic picked, input logic [3:0] chosen,
                                              input logic fb, input logic [1:0] status,
                                              input logic [4:0] total);
        return {picked, chosen, fb, status, total};
    endfunction

    function automatic plan_row_t op_row(input logic [CMD_W-1:0] cmd,
                                         input logic [VAL_W-1:0] value,
                                         input logic [SLOT_W-1:0] slot);
        plan_row_t r;
        r.kind    = ROW_ITEM;
        r.cmd     = cmd;
        r.value   = value;
        r.slot    = slot;
        r.reg_sel = REG_POLICY;
        r.fixed   = 1'b0;
        r.want    = '0;
        return r;
    endfunction

    function automatic plan_row_t op_fixed(input logic [CMD_W-1:0] cmd,
                                           input logic [VAL_W-1:0] value,
                                           input logic [SLOT_W-1:0] slot,
                                           input sched_result_t want);
        plan_row_t r;
        r       = op_row(cmd, value, slot);
        r.fixed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] sel,
                                          input logic [VAL_W-1:0] value);
        plan_row_t r;
        r         = op_row(CMD_NOP, value, '0);
        r.kind    = ROW_REG;
        r.reg_sel = sel;
        return r;
    endfunction

    // next table state and result for one accepted command
    task automatic predict_schedule(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] size,
                                    input logic [SLOT_W-1:0] slot, output sched_result_t r);
        int               pick;
        int               pos;
        logic [VAL_W-1:0] best;
        r    = '0;
        pick = -1;
        best = '0;
        case (cmd)
            CMD_ADD: begin
                if (n_entries < MAX_ENTRIES) begin
                    owed_bytes[n_entries] = size;
                    n_entries = n_entries + 1'b1;
                end else begin
                    r.status = STATUS_FULL;
                end
            end
            CMD_SERVE: begin
                if (n_entries == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    if (policy_reg == POLICY_SMALLEST) begin
                        for (int i = 0; i < int'(n_entries); i++) begin
                            if (owed_bytes[i] != 0 && (pick < 0 || owed_bytes[i] < best)) begin
                                pick = i;
                                best = owed_bytes[i];
                            end
                        end
                    end else if (policy_reg == POLICY_RR) begin
                        // scan starts just past the last pick and wraps
                        pos = (int'(rr_last) + 1) % int'(n_entries);
                        for (int k = 0; k < int'(n_entries); k++) begin
                            if (pick < 0 && owed_bytes[pos] != 0) begin
                                pick = pos;
                            end
                            pos = (pos + 1) % int'(n_entries);
                        end
                        rr_last = (pick < 0) ? '0 : IDX_W'(pick);
                    end else begin
                        for (int i = 0; i < int'(n_entries); i++) begin
                            if (pick < 0 && owed_bytes[i] != 0) begin
                                pick = i;
                            end
                        end
                    end
                    // nothing pending: entry 0 is charged anyway
                    if (pick < 0) begin
                        pick       = 0;
                        r.fallback = 1'b1;
                    end
                    r.picked = 1'b1;
                    r.chosen = CHOSEN_W'(pick);
                    owed_bytes[pick] = (owed_bytes[pick] > charge_reg) ?
                                       owed_bytes[pick] - charge_reg : '0;
                end
            end
            CMD_REMOVE: begin
                if (slot < n_entries) begin
                    for (int i = int'(slot); i + 1 < int'(n_entries); i++) begin
                        owed_bytes[i] = owed_bytes[i + 1];
                    end
                    n_entries = n_entries - 1'b1;
                end else begin
                    r.status = STATUS_EMPTY;
                end
            end
            default: begin
            end
        endcase
        r.total = n_entries;
    endtask

    // register writes only once every expected result has been seen
    task automatic program_register(input logic [CFG_IDX_W-1:0] sel,
                                    input logic [CFG_DATA_W-1:0] data);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (sel == REG_POLICY) begin
            policy_reg = data[POLICY_W-1:0];
        end else begin
            charge_reg = data[VAL_W-1:0];
        end
    endtask

    // one command transfer, optionally preceded by a random gap
    task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] size,
                                input logic [SLOT_W-1:0] slot, input bit fixed,
                                input sched_result_t want);
        sched_result_t predicted;
        if (!steady && $urandom_range(0, 99) < 24) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_size  <= size;
        s_slot  <= slot;
        do @(posedge aclk); while (!s_ready);
        predict_schedule(cmd, size, slot, predicted);
        pending_results.push_back(fixed ? want : predicted);
    endtask

    // result checking and random back-pressure
    always @(posedge aclk) begin
        sched_result_t got;
        sched_result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_picked, m_chosen_index, m_fallback, m_status, m_entry_total};
            if (pending_results.size() == 0) begin
                err_count++;
                if (err_count <= 10) begin
                    $display("unexpected result at %0t: picked %0d chosen %0d status %0d",
                             $time, got.picked, got.chosen, got.status);
                end
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    err_count++;
                    if (err_count <= 10) begin
                        $display("mismatch at %0t (expected/actual): picked %0d/%0d chosen %0d/%0d",
                                 $time, want.picked, got.picked, want.chosen, got.chosen);
                        $display("  fallback %0d/%0d status %0d/%0d total %0d/%0d",
                                 want.fallback, got.fallback, want.status, got.status,
                                 want.total, got.total);
                    end
                end
            end
        end
        m_ready <= steady || ($urandom_range(0, 99) >= 24);
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int                 sent;
        int                 pick;
        bit                 filling;
        logic [CMD_W-1:0]   cmd;
        logic [VAL_W-1:0]   size;
        logic [SLOT_W-1:0]  slot;
        logic [VAL_W-1:0]   charge;

        foreach (owed_bytes[i]) owed_bytes[i] = '0;
        filling = 1'b1;

        // directed: empty table, extremes, ties, fallback, stale pointer, zero charge
        plan.push_back(op_fixed(CMD_SERVE, 16'h0000, 4'h0, outcome(0, 0, 0, STATUS_EMPTY, 0)));
        plan.push_back(op_fixed(CMD_REMOVE, 16'h0000, 4'h0, outcome(0, 0, 0, STATUS_EMPTY, 0)));
        plan.push_back(op_fixed(CMD_NOP, 16'hFFFF, 4'hF, outcome(0, 0, 0, STATUS_OK, 0)));
        plan.push_back(op_fixed(CMD_ADD, 16'hFFFF, 4'hF, outcome(0, 0, 0, STATUS_OK, 1)));
        plan.push_back(op_fixed(CMD_ADD, 16'd50, 4'h0, outcome(0, 0, 0, STATUS_OK, 2)));
        plan.push_back(op_fixed(CMD_ADD, 16'd50, 4'h0, outcome(0, 0, 0, STATUS_OK, 3)));
        plan.push_back(op_fixed(CMD_ADD, 16'd0, 4'h0, outcome(0, 0, 0, STATUS_OK, 4)));
        plan.push_back(op_row(CMD_SERVE, 16'h0000, 4'h0));
        plan.push_back(op_row(CMD_SERVE, 16'hFFFF, 4'hF));
        plan.push_back(op_row(CMD_SERVE, 16'h0000, 4'h0));
        plan.push_back(reg_row(REG_CHARGE, 16'hFFFF));
        plan.push_back(op_row(CMD_SERVE, 16'h0000, 4'h0));
        plan.push_back(op_fixed(CMD_SERVE, 16'h0000, 4'h0, outcome(1, 0, 1, STATUS_OK, 4)));
        plan.push_back(reg_row(REG_POLICY, 16'(POLICY_RR)));
        plan.push_back(op_row(CMD_ADD, 16'd1, 4'h0));
        plan.push_back(op_row(CMD_SERVE, 16'h0000, 4'h0));
        plan.push_back(op_row(CMD_REMOVE, 16'h0000, 4'h4));
        plan.push_back(op_row(CMD_SERVE, 16'h0000, 4'h0));
        plan.push_back(reg_row(REG_POLICY, 16'(POLICY_ALIAS_FIRST)));
        plan.push_back(reg_row(REG_CHARGE, 16'h0000));
        plan.push_back(op_row(CMD_ADD, 16'd7, 4'h0));
        plan.push_back(op_row(CMD_SERVE, 16'h0000, 4'h0));
        plan.push_back(op_row(CMD_SERVE, 16'h0000, 4'h0));
        plan.push_back(op_fixed(CMD_REMOVE, 16'h0000, 4'hF, outcome(0, 0, 0, STATUS_EMPTY, 5)));
        plan.push_back(op_row(CMD_REMOVE, 16'h0000, 4'h0));
        plan.push_back(op_row(CMD_REMOVE, 16'h0000, 4'h3));
        plan.push_back(op_fixed(CMD_REMOVE, 16'h0000, 4'h3, outcome(0, 0, 0, STATUS_EMPTY, 3)));

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_REG) begin
                program_register(plan[i].reg_sel, plan[i].value);
            end else begin
                send_command(plan[i].cmd, plan[i].value, plan[i].slot, plan[i].fixed,
                             plan[i].want);
            end
        end

        // random phases, each with its own policy and charge
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0: charge = 16'd1;
                1: charge = 16'hFFFF;
                3: charge = 16'd0;
                6: charge = 16'($urandom);
                default: charge = 16'($urandom_range(2, 400));
            endcase
            program_register(REG_POLICY, {14'($urandom), policy_seq[ph]});
            program_register(REG_CHARGE, charge);
            steady = (ph == 4);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                // swing between filling and draining so both full and empty are hit
                if (n_entries == MAX_ENTRIES && $urandom_range(0, 3) == 0) filling = 1'b0;
                if (n_entries == 0 && $urandom_range(0, 1) == 0) filling = 1'b1;
                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    cmd = CMD_NOP;
                end else if (pick < (filling ? 53 : 18)) begin
                    cmd = CMD_ADD;
                end else if (pick < (filling ? 88 : 63)) begin
                    cmd = CMD_SERVE;
                end else begin
                    cmd = CMD_REMOVE;
                end
                pick = $urandom_range(0, 99);
                if (pick < 10) begin
                    size = 16'h0000;
                end else if (pick < 20) begin
                    size = 16'hFFFF;
                end else if (pick < 70) begin
                    size = 16'($urandom_range(1, 300));
                end else begin
                    size = 16'($urandom);
                end
                if (n_entries != 0 && $urandom_range(0, 99) < 85) begin
                    slot = 4'($urandom_range(0, int'(n_entries) - 1));
                end else begin
                    slot = 4'($urandom);
                end
                // sender holds off until the result path is empty
                if ($urandom_range(0, 49) == 0 && pending_results.size() != 0) begin
                    s_valid <= 1'b0;
                    do @(posedge aclk); while (pending_results.size() != 0);
                end
                send_command(cmd, size, slot, 1'b0, '0);
                if (cmd != CMD_NOP) sent++;
            end
        end

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
